// ----- rtl/core/cbd_pkg.sv -----
// shared types and constants for the chunked body decoder
// no dependencies; used by the stream interfaces and the top level
package cbd_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [2:0] status_t;

  // default width of the chunk size register
  localparam int unsigned SizeBitsDef = 32;
  localparam int unsigned MaxBodyW    = 32;

  // body limit after reset: 1 MiB
  localparam logic [MaxBodyW-1:0] MaxBodyRst = MaxBodyW'(1024 * 1024);

  // result status codes
  localparam status_t StatBusy    = 3'd0;
  localparam status_t StatDone    = 3'd1;
  localparam status_t StatBadSize = 3'd2;
  localparam status_t StatBadEnd  = 3'd3;
  localparam status_t StatTooBig  = 3'd4;

  // characters of the line syntax
  localparam byte_t ChCr   = 8'h0d;
  localparam byte_t ChLf   = 8'h0a;
  localparam byte_t ChSemi = 8'h3b;
  localparam byte_t ChSp   = 8'h20;
  localparam byte_t ChTab  = 8'h09;

  // hex digit decode: bit 4 set when the byte is a hex digit, low bits hold its value
  function automatic logic [4:0] hex_nibble(input byte_t c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- rtl/core/cbd_in_if.sv -----
// input word channel of the chunked body decoder: one raw body byte
// depends on cbd_pkg
interface cbd_in_if;
  logic          valid;
  logic          ready;
  cbd_pkg::byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

// ----- rtl/core/cbd_out_if.sv -----
// result word channel of the chunked body decoder: payload byte and status
// depends on cbd_pkg
interface cbd_out_if;
  logic            valid;
  logic            ready;
  logic            data_valid;
  cbd_pkg::byte_t   data_byte;
  cbd_pkg::status_t status;

  modport source (output valid, output data_valid, output data_byte, output status,
                  input ready);
  modport sink   (input valid, input data_valid, input data_byte, input status,
                  output ready);
endinterface

// ----- rtl/core/chunked_body_decoder.sv -----
// chunked transfer body decoder, top level
// depends on cbd_pkg, cbd_in_if and cbd_out_if
//
// Takes one raw byte of a chunked transfer body per input word and returns exactly one result
// word for it: data_valid/data_byte carry the byte when it is chunk payload, status tells
// busy (0), complete (1), bad chunk size (2), bad chunk ending (3) or body too large (4).
// Completion and errors stick until reset; later bytes are taken and answered with the same
// status. Each result is registered in the output register, which passes ready through,
// so the block runs at one word per cycle as long as the sink takes results, and stalls
// only when the output register is full and not being drained. max_body is written through
// cfg_we_i/cfg_wdata_i; the user must write it only while no word is in flight, which the
// block does not enforce. There is no clearing pass after reset: the block is ready at once.
module chunked_body_decoder #(
  parameter int unsigned SIZE_BITS = cbd_pkg::SizeBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [cbd_pkg::MaxBodyW-1:0]    cfg_wdata_i,
  cbd_in_if.sink                          in_i,
  cbd_out_if.source                       out_o
);
  import cbd_pkg::*;

  // decoder phase, one-hot
  typedef enum logic [7:0] {
    PhSize    = 8'b0000_0001,
    PhData    = 8'b0000_0010,
    PhEnd     = 8'b0000_0100,
    PhTrail   = 8'b0000_1000,
    PhDone    = 8'b0001_0000,
    PhErrSize = 8'b0010_0000,
    PhErrEnd  = 8'b0100_0000,
    PhErrBig  = 8'b1000_0000
  } phase_e;

  // flags of the current size or trailer line
  typedef struct packed {
    logic digits;  // hex digits seen
    logic tspace;  // space or tab after the digits
    logic ext;     // inside a chunk extension
    logic bad;     // line is malformed
    logic cr;      // last byte was CR
    logic text;    // trailer line has content
  } line_flags_t;

  phase_e                phase_q, phase_d;
  logic [SIZE_BITS-1:0]  accum_q, accum_d;
  line_flags_t           flags_q, flags_d;
  logic [SIZE_BITS-1:0]  chunk_left_q, chunk_left_d;
  logic [MaxBodyW-1:0]   body_total_q, body_total_d;
  logic                  ending_q, ending_d;
  logic [MaxBodyW-1:0]   max_body_q;

  // output register
  logic    out_valid_q;
  logic    out_dv_q, out_dv_d;
  byte_t   out_byte_q, out_byte_d;
  status_t out_stat_q, out_stat_d;

  logic       acc;
  byte_t      c;
  logic [4:0] hex;

  // a word enters whenever the output register is empty or being drained
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign acc        = in_i.valid && in_i.ready;
  assign c          = in_i.in_byte;
  assign hex        = hex_nibble(c);

  always_comb begin
    phase_d      = phase_q;
    accum_d      = accum_q;
    flags_d      = flags_q;
    chunk_left_d = chunk_left_q;
    body_total_d = body_total_q;
    ending_d     = ending_q;
    out_dv_d     = 1'b0;
    out_byte_d   = '0;

    case (phase_q)
      PhSize: begin
        if (c == ChLf && flags_q.cr) begin
          // end of size line
          if (flags_q.bad || !flags_q.digits) begin
            phase_d = PhErrSize;
          end else if (accum_q == '0) begin
            phase_d = PhTrail;
          end else begin
            chunk_left_d = accum_q;
            phase_d      = PhData;
          end
          accum_d = '0;
          flags_d = '0;
        end else begin
          // outside an extension, a pending CR that is not followed by LF counts as a stray character
          if (flags_q.cr && !flags_q.ext) begin
            flags_d.bad = 1'b1;
          end
          flags_d.cr = 1'b0;
          if (c == ChCr) begin
            flags_d.cr = 1'b1;
          end else if (!flags_q.ext) begin
            if (c == ChSemi) begin
              flags_d.ext = 1'b1;
            end else if (c == ChSp || c == ChTab) begin
              if (flags_q.digits) begin
                flags_d.tspace = 1'b1;
              end
            end else if (!hex[4] || flags_q.tspace) begin
              flags_d.bad = 1'b1;
            end else begin
              // top nibble in use means the value no longer fits
              if (accum_q[SIZE_BITS-1 -: 4] != 4'd0) begin
                flags_d.bad = 1'b1;
              end
              accum_d        = {accum_q[SIZE_BITS-5:0], hex[3:0]};
              flags_d.digits = 1'b1;
            end
          end
        end
      end
      PhData: begin
        if (body_total_q >= max_body_q) begin
          phase_d = PhErrBig;
        end else begin
          out_dv_d     = 1'b1;
          out_byte_d   = c;
          body_total_d = body_total_q + MaxBodyW'(1);
          chunk_left_d = chunk_left_q - SIZE_BITS'(1);
          if (chunk_left_q == SIZE_BITS'(1)) begin
            phase_d  = PhEnd;
            ending_d = 1'b0;
          end
        end
      end
      PhEnd: begin
        if (!ending_q) begin
          if (c == ChCr) begin
            ending_d = 1'b1;
          end else begin
            phase_d = PhErrEnd;
          end
        end else begin
          ending_d = 1'b0;
          phase_d  = (c == ChLf) ? PhSize : PhErrEnd;
        end
      end
      PhTrail: begin
        if (c == ChLf && flags_q.cr) begin
          // an empty line closes the trailer section
          if (!flags_q.text) begin
            phase_d = PhDone;
          end
          flags_d = '0;
        end else begin
          if (flags_q.cr) begin
            flags_d.text = 1'b1;
          end
          flags_d.cr = 1'b0;
          if (c == ChCr) begin
            flags_d.cr = 1'b1;
          end else begin
            flags_d.text = 1'b1;
          end
        end
      end
      default: begin
        // complete or failed: hold
      end
    endcase

    case (phase_d)
      PhDone:    out_stat_d = StatDone;
      PhErrSize: out_stat_d = StatBadSize;
      PhErrEnd:  out_stat_d = StatBadEnd;
      PhErrBig:  out_stat_d = StatTooBig;
      default:   out_stat_d = StatBusy;
    endcase
  end

  // decoder state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSize;
      accum_q      <= '0;
      flags_q      <= '0;
      chunk_left_q <= '0;
      body_total_q <= '0;
      ending_q     <= 1'b0;
    end else if (acc) begin
      phase_q      <= phase_d;
      accum_q      <= accum_d;
      flags_q      <= flags_d;
      chunk_left_q <= chunk_left_d;
      body_total_q <= body_total_d;
      ending_q     <= ending_d;
    end
  end

  // body limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_body_q <= MaxBodyRst;
    end else if (cfg_we_i) begin
      max_body_q <= cfg_wdata_i;
    end
  end

  // result word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (acc) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_dv_q   <= out_dv_d;
      out_byte_q <= out_byte_d;
      out_stat_q <= out_stat_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.data_valid = out_dv_q;
  assign out_o.data_byte  = out_byte_q;
  assign out_o.status     = out_stat_q;

  // a payload byte only leaves while the body is still in progress
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_dv_q) |-> (out_stat_q == StatBusy))
    else $error("payload word carries a final status");

  // completion and errors never change once reached
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhDone || phase_q == PhErrSize || phase_q == PhErrEnd ||
     phase_q == PhErrBig) |=> $stable(phase_q))
    else $error("sticky phase left");

  // a chunk in progress always has bytes left
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhData) |-> (chunk_left_q != '0))
    else $error("payload phase with empty chunk");

  // an accepted payload byte within the limit shows up as a payload word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && phase_q == PhData && body_total_q < max_body_q) |=> (out_valid_q && out_dv_q))
    else $error("payload byte lost");

endmodule
